[src/tirp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text index record parser package
// Shared request types, item kind codes, byte constants and parse phases.
// ----------------------------------------------------------------------------
package tirp_pkg;

    localparam int WINDOW_DEPTH = 6;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] BYTE_AUTHOR_TAG = 8'h01;
    localparam logic [7:0] BYTE_BOOK_TAG   = 8'h02;
    localparam logic [7:0] BYTE_HDR_TAIL   = 8'hEF;
    localparam logic [7:0] BYTE_AUTHOR_END = 8'h80;
    localparam logic [7:0] BYTE_BOOK_END   = 8'h81;
    localparam logic [7:0] BYTE_ID_TERM    = 8'hFF;
    localparam logic [7:0] BYTE_LEVEL_TAG  = 8'h11;
    localparam logic [7:0] CHAR_MASK       = 8'h7F;

    localparam logic [2:0] KIND_AUTHOR_ID   = 3'd0;
    localparam logic [2:0] KIND_AUTHOR_NAME = 3'd1;
    localparam logic [2:0] KIND_BOOK_ID     = 3'd2;
    localparam logic [2:0] KIND_BLOCK_NUM   = 3'd3;
    localparam logic [2:0] KIND_TITLE       = 3'd4;
    localparam logic [2:0] KIND_LEVEL_ID    = 3'd5;
    localparam logic [2:0] KIND_LEVEL_CHAR  = 3'd6;
    localparam logic [2:0] KIND_RECORD_END  = 3'd7;

    typedef enum logic [3:0] {
        PH_SEARCH    = 4'd0,
        PH_ID        = 4'd1,
        PH_SKIP      = 4'd2,
        PH_COUNT     = 4'd3,
        PH_NAME      = 4'd4,
        PH_LVL_CHECK = 4'd5,
        PH_LVL_ID    = 4'd6,
        PH_LVL_COUNT = 4'd7,
        PH_LVL_CHARS = 4'd8
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  item_kind;
        logic [15:0] item_value;
    } t_out_req;

endpackage

[src/text_index_record_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text index record parser core
// Scans an index byte stream for author and book headers and emits tagged
// character, block number, level and record end items.
// ----------------------------------------------------------------------------
// One input byte is accepted per cycle whenever the four-entry result queue has
// room for two results; a byte yields zero, one or two results. The parse state
// updates in the cycle of acceptance and its results are written into the queue
// at the same clock edge. The queue hands out at most one result per cycle on
// the output side, and only while the consumer holds i_out_ready high.
module text_index_record_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tirp_pkg::t_in_req   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tirp_pkg::t_out_req  o_out
);

    logic [7:0]       r_window [tirp_pkg::WINDOW_DEPTH];
    logic [7:0]       n_window [tirp_pkg::WINDOW_DEPTH];
    logic [2:0]       r_fill, n_fill;
    tirp_pkg::t_phase r_phase, n_phase;
    logic             r_is_book, n_is_book;
    logic [7:0]       r_bytes_left, n_bytes_left;
    logic [1:0]       r_skip_left, n_skip_left;

    tirp_pkg::t_out_req r_queue [tirp_pkg::QUEUE_DEPTH];
    logic [1:0]         r_wr_ptr, r_rd_ptr;
    logic [2:0]         r_count, n_count;

    logic               in_acc, out_acc;
    logic               emit_a, emit_end;
    tirp_pkg::t_out_req item_a, item_end, push0, push1;
    logic [7:0]         b;
    logic [7:0]         dec_left;

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_count < 3'd3);
    assign o_out_valid = (r_count != 3'd0);
    assign o_out       = r_queue[r_rd_ptr];
    assign b           = i_in.in_byte;
    assign dec_left    = (r_bytes_left != 8'd0) ? (r_bytes_left - 8'd1) : 8'd0;

    always_comb begin
        n_window     = r_window;
        n_fill       = r_fill;
        n_phase      = r_phase;
        n_is_book    = r_is_book;
        n_bytes_left = r_bytes_left;
        n_skip_left  = r_skip_left;
        emit_a       = 1'b0;
        item_a       = '0;
        emit_end     = 1'b0;
        item_end     = '{item_kind: tirp_pkg::KIND_RECORD_END, item_value: 16'd0};

        unique case (r_phase)
            tirp_pkg::PH_SEARCH: begin
                if (r_fill >= 3'(tirp_pkg::WINDOW_DEPTH)) begin
                    if (r_window[5] == tirp_pkg::BYTE_HDR_TAIL
                        && r_window[0] == tirp_pkg::BYTE_AUTHOR_TAG
                        && b == tirp_pkg::BYTE_AUTHOR_END) begin
                        n_is_book = 1'b0;
                        n_phase   = tirp_pkg::PH_ID;
                    end else if (r_window[5] == tirp_pkg::BYTE_HDR_TAIL
                        && r_window[0] == tirp_pkg::BYTE_BOOK_TAG
                        && b == tirp_pkg::BYTE_BOOK_END) begin
                        n_is_book = 1'b1;
                        n_phase   = tirp_pkg::PH_ID;
                    end else begin
                        for (int i = 0; i < tirp_pkg::WINDOW_DEPTH - 1; i++) begin
                            n_window[i] = r_window[i + 1];
                        end
                        n_window[tirp_pkg::WINDOW_DEPTH - 1] = b;
                    end
                end else begin
                    n_window[r_fill] = b;
                    n_fill           = r_fill + 3'd1;
                end
            end
            tirp_pkg::PH_ID: begin
                if (b == tirp_pkg::BYTE_ID_TERM) begin
                    if (r_is_book) begin
                        emit_a = 1'b1;
                        item_a = '{item_kind: tirp_pkg::KIND_BLOCK_NUM,
                                   item_value: {r_window[3], r_window[4]}};
                    end
                    n_skip_left = 2'd2;
                    n_phase     = tirp_pkg::PH_SKIP;
                end else begin
                    emit_a = 1'b1;
                    item_a = '{item_kind: r_is_book ? tirp_pkg::KIND_BOOK_ID
                                                    : tirp_pkg::KIND_AUTHOR_ID,
                               item_value: {8'd0, b & tirp_pkg::CHAR_MASK}};
                end
            end
            tirp_pkg::PH_SKIP: begin
                if (r_skip_left != 2'd0) begin
                    n_skip_left = r_skip_left - 2'd1;
                end
                if (r_skip_left <= 2'd1) begin
                    n_phase = tirp_pkg::PH_COUNT;
                end
            end
            tirp_pkg::PH_COUNT: begin
                n_bytes_left = b;
                if (b != 8'd0) begin
                    n_phase = tirp_pkg::PH_NAME;
                end else if (r_is_book) begin
                    n_phase = tirp_pkg::PH_LVL_CHECK;
                end else begin
                    n_window     = '{default: 8'd0};
                    n_fill       = 3'd0;
                    n_phase      = tirp_pkg::PH_SEARCH;
                    n_bytes_left = 8'd0;
                    n_skip_left  = 2'd0;
                end
            end
            tirp_pkg::PH_NAME: begin
                emit_a       = 1'b1;
                item_a       = '{item_kind: r_is_book ? tirp_pkg::KIND_TITLE
                                                      : tirp_pkg::KIND_AUTHOR_NAME,
                                 item_value: {8'd0, b}};
                n_bytes_left = dec_left;
                if (dec_left == 8'd0) begin
                    if (r_is_book) begin
                        n_phase = tirp_pkg::PH_LVL_CHECK;
                    end else begin
                        n_window     = '{default: 8'd0};
                        n_fill       = 3'd0;
                        n_phase      = tirp_pkg::PH_SEARCH;
                        n_bytes_left = 8'd0;
                        n_skip_left  = 2'd0;
                    end
                end
            end
            tirp_pkg::PH_LVL_CHECK: begin
                if (b == tirp_pkg::BYTE_LEVEL_TAG) begin
                    n_phase = tirp_pkg::PH_LVL_ID;
                end else begin
                    emit_a       = 1'b1;
                    item_a       = item_end;
                    n_is_book    = 1'b0;
                    n_window     = '{default: 8'd0};
                    n_window[0]  = b;
                    n_fill       = 3'd1;
                    n_phase      = tirp_pkg::PH_SEARCH;
                    n_bytes_left = 8'd0;
                    n_skip_left  = 2'd0;
                end
            end
            tirp_pkg::PH_LVL_ID: begin
                emit_a  = 1'b1;
                item_a  = '{item_kind: tirp_pkg::KIND_LEVEL_ID, item_value: {8'd0, b}};
                n_phase = tirp_pkg::PH_LVL_COUNT;
            end
            tirp_pkg::PH_LVL_COUNT: begin
                n_bytes_left = b;
                n_phase      = (b == 8'd0) ? tirp_pkg::PH_LVL_CHECK
                                           : tirp_pkg::PH_LVL_CHARS;
            end
            tirp_pkg::PH_LVL_CHARS: begin
                emit_a       = 1'b1;
                item_a       = '{item_kind: tirp_pkg::KIND_LEVEL_CHAR,
                                 item_value: {8'd0, b}};
                n_bytes_left = dec_left;
                if (dec_left == 8'd0) begin
                    n_phase = tirp_pkg::PH_LVL_CHECK;
                end
            end
            default: begin
                n_window     = '{default: 8'd0};
                n_fill       = 3'd0;
                n_phase      = tirp_pkg::PH_SEARCH;
                n_bytes_left = 8'd0;
                n_skip_left  = 2'd0;
                n_is_book    = 1'b0;
            end
        endcase

        if (i_in.stream_end) begin
            emit_end     = (n_phase != tirp_pkg::PH_SEARCH) && n_is_book;
            n_window     = '{default: 8'd0};
            n_fill       = 3'd0;
            n_phase      = tirp_pkg::PH_SEARCH;
            n_bytes_left = 8'd0;
            n_skip_left  = 2'd0;
            n_is_book    = 1'b0;
        end
    end

    assign push0 = emit_a ? item_a : item_end;
    assign push1 = item_end;

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            n_count = n_count + {2'd0, emit_a} + {2'd0, emit_end};
        end
        if (out_acc) begin
            n_count = n_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= '{default: 8'd0};
            r_fill       <= 3'd0;
            r_phase      <= tirp_pkg::PH_SEARCH;
            r_is_book    <= 1'b0;
            r_bytes_left <= 8'd0;
            r_skip_left  <= 2'd0;
        end else if (in_acc) begin
            r_window     <= n_window;
            r_fill       <= n_fill;
            r_phase      <= n_phase;
            r_is_book    <= n_is_book;
            r_bytes_left <= n_bytes_left;
            r_skip_left  <= n_skip_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (emit_a || emit_end)) begin
            r_queue[r_wr_ptr] <= push0;
            if (emit_a && emit_end) begin
                r_queue[r_wr_ptr + 2'd1] <= push1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + {1'b0, emit_a} + {1'b0, emit_end};
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(tirp_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[1:0])
        else $error("queue pointers disagree with count");

    a_skip_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tirp_pkg::PH_SKIP) |-> (r_skip_left != 2'd0))
        else $error("skip phase with no bytes to skip");

    a_level_book: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tirp_pkg::PH_LVL_CHECK || r_phase == tirp_pkg::PH_LVL_ID
         || r_phase == tirp_pkg::PH_LVL_COUNT || r_phase == tirp_pkg::PH_LVL_CHARS)
        |-> r_is_book)
        else $error("level phase outside a book record");

    a_window_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != tirp_pkg::PH_SEARCH) |-> (r_fill == 3'(tirp_pkg::WINDOW_DEPTH)))
        else $error("record parse without a full header window");
`endif

endmodule

[verif/tirp_item_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text index record parser item checker
// Watches both request channels of the parser core, predicts the items that
// each accepted byte produces, and compares every accepted output request
// against the oldest predicted item.
// ----------------------------------------------------------------------------
module tirp_item_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  tirp_pkg::t_in_req  i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  tirp_pkg::t_out_req i_out_req,
    output int                 o_pending,
    output int                 o_fail_count
);

    logic [7:0]         win [0:tirp_pkg::WINDOW_DEPTH-1];
    logic [2:0]         win_fill;
    tirp_pkg::t_phase   phase;
    logic               in_book;
    logic [7:0]         chars_left;
    logic [1:0]         skip_left;
    tirp_pkg::t_out_req pending_items [$];
    tirp_pkg::t_out_req want;
    int                 mismatches;

    function automatic void add_item(input logic [2:0] kind, input logic [15:0] value);
        tirp_pkg::t_out_req item;
        item.item_kind  = kind;
        item.item_value = value;
        pending_items.push_back(item);
    endfunction

    function automatic void clear_search();
        for (int k = 0; k < tirp_pkg::WINDOW_DEPTH; k++) begin
            win[k] = 8'h00;
        end
        win_fill   = 3'd0;
        phase      = tirp_pkg::PH_SEARCH;
        chars_left = 8'h00;
        skip_left  = 2'd0;
    endfunction

    function automatic void text_done();
        if (in_book) begin
            phase = tirp_pkg::PH_LVL_CHECK;
        end else begin
            clear_search();
        end
    endfunction

    function automatic void parse_index_byte(input tirp_pkg::t_in_req req);
        logic [7:0] b;
        b = req.in_byte;
        case (phase)
            tirp_pkg::PH_SEARCH: begin
                if (win_fill >= 3'd6) begin
                    if (win[5] == tirp_pkg::BYTE_HDR_TAIL && win[0] == tirp_pkg::BYTE_AUTHOR_TAG &&
                        b == tirp_pkg::BYTE_AUTHOR_END) begin
                        in_book = 1'b0;
                        phase   = tirp_pkg::PH_ID;
                    end else if (win[5] == tirp_pkg::BYTE_HDR_TAIL &&
                                 win[0] == tirp_pkg::BYTE_BOOK_TAG &&
                                 b == tirp_pkg::BYTE_BOOK_END) begin
                        in_book = 1'b1;
                        phase   = tirp_pkg::PH_ID;
                    end else begin
                        for (int k = 0; k < tirp_pkg::WINDOW_DEPTH - 1; k++) begin
                            win[k] = win[k+1];
                        end
                        win[5] = b;
                    end
                end else begin
                    win[win_fill] = b;
                    win_fill++;
                end
            end
            tirp_pkg::PH_ID: begin
                if (b == tirp_pkg::BYTE_ID_TERM) begin
                    if (in_book) begin
                        add_item(tirp_pkg::KIND_BLOCK_NUM, {win[3], win[4]});
                    end
                    skip_left = 2'd2;
                    phase     = tirp_pkg::PH_SKIP;
                end else begin
                    add_item(in_book ? tirp_pkg::KIND_BOOK_ID : tirp_pkg::KIND_AUTHOR_ID,
                             {8'h00, b & tirp_pkg::CHAR_MASK});
                end
            end
            tirp_pkg::PH_SKIP: begin
                if (skip_left > 2'd0) skip_left--;
                if (skip_left == 2'd0) phase = tirp_pkg::PH_COUNT;
            end
            tirp_pkg::PH_COUNT: begin
                chars_left = b;
                if (b == 8'h00) begin
                    text_done();
                end else begin
                    phase = tirp_pkg::PH_NAME;
                end
            end
            tirp_pkg::PH_NAME: begin
                add_item(in_book ? tirp_pkg::KIND_TITLE : tirp_pkg::KIND_AUTHOR_NAME,
                         {8'h00, b});
                if (chars_left > 8'h00) chars_left--;
                if (chars_left == 8'h00) text_done();
            end
            tirp_pkg::PH_LVL_CHECK: begin
                if (b == tirp_pkg::BYTE_LEVEL_TAG) begin
                    phase = tirp_pkg::PH_LVL_ID;
                end else begin
                    add_item(tirp_pkg::KIND_RECORD_END, 16'h0000);
                    in_book = 1'b0;
                    clear_search();
                    win[0]   = b;
                    win_fill = 3'd1;
                end
            end
            tirp_pkg::PH_LVL_ID: begin
                add_item(tirp_pkg::KIND_LEVEL_ID, {8'h00, b});
                phase = tirp_pkg::PH_LVL_COUNT;
            end
            tirp_pkg::PH_LVL_COUNT: begin
                chars_left = b;
                phase      = (b == 8'h00) ? tirp_pkg::PH_LVL_CHECK : tirp_pkg::PH_LVL_CHARS;
            end
            tirp_pkg::PH_LVL_CHARS: begin
                add_item(tirp_pkg::KIND_LEVEL_CHAR, {8'h00, b});
                if (chars_left > 8'h00) chars_left--;
                if (chars_left == 8'h00) phase = tirp_pkg::PH_LVL_CHECK;
            end
            default: begin
                clear_search();
                in_book = 1'b0;
            end
        endcase
        if (req.stream_end) begin
            if (phase != tirp_pkg::PH_SEARCH && in_book) begin
                add_item(tirp_pkg::KIND_RECORD_END, 16'h0000);
            end
            clear_search();
            in_book = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_search();
            in_book = 1'b0;
            pending_items.delete();
            mismatches = 0;
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_items.size() == 0) begin
                    $error("unexpected item: item_kind %0d, item_value 0x%h",
                           i_out_req.item_kind, i_out_req.item_value);
                    mismatches++;
                end else begin
                    want = pending_items.pop_front();
                    if (want.item_kind !== i_out_req.item_kind) begin
                        $error("item_kind: expected %0d, got %0d",
                               want.item_kind, i_out_req.item_kind);
                        mismatches++;
                    end
                    if (want.item_value !== i_out_req.item_value) begin
                        $error("item_value: expected 0x%h, got 0x%h",
                               want.item_value, i_out_req.item_value);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_index_byte(i_in_req);
            end
            o_pending    <= pending_items.size();
            o_fail_count <= mismatches;
        end
    end

endmodule

[verif/text_index_record_parser_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text index record parser core testbench
// Streams directed and random index bytes into the parser core with random
// gaps and output stalls, including a long output hold-off, while the item
// checker predicts and compares every emitted item.
// ----------------------------------------------------------------------------
module text_index_record_parser_core_test;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    tirp_pkg::t_in_req  i_in        = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    tirp_pkg::t_out_req o_out;

    int                 pending;
    int                 fail_count;
    tirp_pkg::t_in_req  byte_plan [$];
    int                 planned     = 0;
    bit                 tx_burst    = 1'b0;
    bit                 rx_burst    = 1'b0;
    int                 tx_gap      = 0;
    int                 rx_gap      = 0;
    int                 rx_hold     = 0;
    int                 rx_hold_req = 0;

    logic [7:0] directed_bytes [0:29] = '{
        8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hEF, 8'h80, 8'hFE, 8'hFF, 8'h55,
        8'hAA, 8'h01, 8'h80,
        8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hEF, 8'h81, 8'h80, 8'hFF, 8'h00,
        8'h00, 8'h01, 8'hFF, 8'h11, 8'hFF, 8'h01, 8'h7F
    };

    text_index_record_parser_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    tirp_item_checker item_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_req     (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_req    (o_out),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] rand_byte(input int hi);
        return 8'($urandom_range(0, hi));
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic last);
        tirp_pkg::t_in_req req;
        req.in_byte    = b;
        req.stream_end = last;
        byte_plan.push_back(req);
        planned++;
    endfunction

    function automatic void add_record(input bit book, input int id_len, input int text_len,
                                       input int level_cnt, input bit cut);
        logic [7:0] rec [$];
        logic [7:0] closer;
        int         lvl_len;
        int         stop;
        rec.push_back(book ? tirp_pkg::BYTE_BOOK_TAG : tirp_pkg::BYTE_AUTHOR_TAG);
        repeat (4) rec.push_back(rand_byte(255));
        rec.push_back(tirp_pkg::BYTE_HDR_TAIL);
        rec.push_back(book ? tirp_pkg::BYTE_BOOK_END : tirp_pkg::BYTE_AUTHOR_END);
        repeat (id_len) rec.push_back(rand_byte(254));
        rec.push_back(tirp_pkg::BYTE_ID_TERM);
        repeat (2) rec.push_back(rand_byte(255));
        rec.push_back(text_len[7:0]);
        repeat (text_len) rec.push_back(rand_byte(255));
        if (book) begin
            repeat (level_cnt) begin
                lvl_len = $urandom_range(0, 4);
                rec.push_back(tirp_pkg::BYTE_LEVEL_TAG);
                rec.push_back(rand_byte(255));
                rec.push_back(lvl_len[7:0]);
                repeat (lvl_len) rec.push_back(rand_byte(255));
            end
            case ($urandom_range(0, 2))
                0: closer = tirp_pkg::BYTE_AUTHOR_TAG;
                1: closer = tirp_pkg::BYTE_BOOK_TAG;
                default: closer = rand_byte(255);
            endcase
            if (closer == tirp_pkg::BYTE_LEVEL_TAG) closer = ~closer;
            rec.push_back(closer);
        end
        stop = cut ? $urandom_range(0, rec.size() - 1) : rec.size() - 1;
        for (int k = 0; k <= stop; k++) begin
            queue_byte(rec[k], k == stop && (cut || $urandom_range(0, 9) == 0));
        end
    endfunction

    function automatic void add_random_traffic(input int target);
        int pick;
        while (planned < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                repeat ($urandom_range(1, 8)) begin
                    queue_byte(rand_byte(255), $urandom_range(0, 19) == 0);
                end
            end else begin
                add_record(1'($urandom_range(0, 1)), $urandom_range(0, 5),
                           ($urandom_range(0, 39) == 0) ? $urandom_range(20, 255)
                                                        : $urandom_range(0, 6),
                           $urandom_range(0, 3), pick < 6);
            end
        end
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        while (byte_plan.size() != 0 || i_in_valid || pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                tx_gap = tx_burst ? 0 : $urandom_range(0, 19);
                if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
            end
            if (!i_in_valid || o_in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (byte_plan.size() != 0) begin
                    i_in       <= byte_plan.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_gap  = 0;
            rx_hold = 0;
        end else begin
            if (i_out_ready && o_out_valid) begin
                rx_gap = rx_burst ? 0 : $urandom_range(0, 19);
                if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
            end
            if (rx_hold_req != 0) begin
                rx_hold     = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_bytes[k]) begin
            queue_byte(directed_bytes[k], k == 29);
        end
        add_random_traffic(350);
        wait_idle();
        rx_hold_req = 400;
        tx_burst    = 1'b1;
        add_record(1'b1, 3, 200, 2, 1'b0);
        wait_idle();
        tx_burst = 1'b0;
        add_random_traffic(750);
        wait_idle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("text_index_record_parser_core: match");
        end else begin
            $display("text_index_record_parser_core: mismatch");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("text_index_record_parser_core: mismatch");
        $finish;
    end

endmodule
